// ===== sv/amtw_pkg.sv =====
// Shared types and codes for the MMU table walk unit.
`timescale 1ns / 1ps

package amtw_pkg;

    localparam int unsigned CfgAddrWidth = 3;
    localparam int unsigned CfgDataWidth = 32;

    typedef enum logic [0:0] {
        FUNC_REQUEST = 1'b0,
        FUNC_REPLY   = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        KIND_FETCH = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_OTHER = 2'd3
    } access_kind_t;

    typedef enum logic [0:0] {
        OUT_DESC_READ = 1'b0,
        OUT_DONE      = 1'b1
    } out_kind_t;

    typedef enum logic [1:0] {
        OUTCOME_OK          = 2'd0,
        OUTCOME_FAULT       = 2'd1,
        OUTCOME_UNSUPPORTED = 2'd2,
        OUTCOME_STRAY       = 2'd3
    } outcome_t;

    typedef enum logic [3:0] {
        FS_NONE             = 4'd0,
        FS_SECTION_XLATE    = 4'd5,
        FS_PAGE_XLATE       = 4'd7,
        FS_SECTION_PERM     = 4'd13,
        FS_PAGE_PERM        = 4'd15
    } fault_status_t;

    localparam logic [1:0] DESC_FAULT   = 2'd0;
    localparam logic [1:0] DESC_COARSE  = 2'd1;
    localparam logic [1:0] DESC_SECTION = 2'd2;
    localparam logic [1:0] DESC_SMALL   = 2'd2;

    localparam logic [0:0] REG_MMU_ENABLE = 1'b0;
    localparam logic [0:0] REG_TABLE_BASE = 1'b1;

    localparam logic [11:0] FSR_WRITE_FLAG = 12'h800;

    typedef struct packed {
        logic        func;
        logic [31:0] virt_addr;
        logic [1:0]  access_kind;
        logic        supervisor;
        logic [31:0] descriptor;
    } req_t;

    typedef struct packed {
        logic        out_kind;
        logic [31:0] address;
        logic [1:0]  outcome;
        logic [31:0] fault_address;
        logic [3:0]  fault_status;
        logic [3:0]  fault_domain;
        logic [11:0] fsr_value;
        logic        fsr_is_data;
    } rsp_t;

endpackage

// ===== sv/amtw_req_if.sv =====
// Request channel interface of the MMU table walk unit.
`timescale 1ns / 1ps

interface amtw_req_if;
    logic            valid;
    logic            ready;
    amtw_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/amtw_rsp_if.sv =====
// Result channel interface of the MMU table walk unit.
`timescale 1ns / 1ps

interface amtw_rsp_if;
    logic            valid;
    logic            ready;
    amtw_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/arm_mmu_table_walk_unit.sv =====
// Two-level page table walker: request decode, descriptor checks, result register.
// Latency: a result is valid in the cycle after its item's transfer.
// Throughput: one item per cycle; the single result register is refilled in the
// cycle it is taken, so input ready stays high unless a result waits unread.
// Reset: walk goes idle, mmu_enable and table_base clear, result register empties.
`timescale 1ns / 1ps

module arm_mmu_table_walk_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    amtw_req_if.sink                               req,
    amtw_rsp_if.source                             rsp,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [amtw_pkg::CfgAddrWidth-1:0]      paddr,
    input  logic [amtw_pkg::CfgDataWidth-1:0]      pwdata,
    output logic [amtw_pkg::CfgDataWidth-1:0]      prdata,
    output logic                                   pready
);
    import amtw_pkg::*;

    typedef enum logic [1:0] {
        WALK_IDLE = 2'd0,
        WALK_L1   = 2'd1,
        WALK_L2   = 2'd2
    } walk_state_t;

    walk_state_t  walk_reg, walk_next;
    logic         mmu_enable_reg;
    logic [31:0]  table_base_reg;
    logic [31:0]  vaddr_reg, vaddr_next;
    logic [1:0]   kind_reg, kind_next;
    logic         priv_reg, priv_next;
    logic [3:0]   domain_reg, domain_next;
    logic         rsp_valid_reg;
    rsp_t         rsp_reg, rsp_next;

    logic         accept;
    logic         cfg_write;
    logic [1:0]   desc_type;
    logic [3:0]   desc_domain;
    logic [1:0]   page_ap;

    function automatic logic ap_allows(logic [1:0] kind, logic priv, logic [1:0] ap);
        logic ok;
        case (ap)
            2'd0:    ok = 1'b0;
            2'd1:    ok = priv;
            2'd2:    ok = priv || (kind != KIND_WRITE);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    function automatic rsp_t make_fault(logic [31:0] va, logic [1:0] kind,
                                        fault_status_t status, logic [3:0] dom);
        rsp_t r;
        r               = '0;
        r.out_kind      = OUT_DONE;
        r.outcome       = OUTCOME_FAULT;
        r.fault_address = va;
        r.fault_status  = status;
        r.fault_domain  = dom;
        r.fsr_value     = {8'd0, status};
        if (kind != KIND_FETCH)
        begin
            r.fsr_value   = r.fsr_value | {4'd0, dom, 4'd0};
            r.fsr_is_data = 1'b1;
        end
        if (kind == KIND_WRITE)
        begin
            r.fsr_value = r.fsr_value | FSR_WRITE_FLAG;
        end
        return r;
    endfunction

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TABLE_BASE) ? table_base_reg
                                                     : {31'd0, mmu_enable_reg};

    assign desc_type   = req.data.descriptor[1:0];
    assign desc_domain = req.data.descriptor[8:5];

    always_comb
    begin
        case (vaddr_reg[11:10])
            2'd0:    page_ap = req.data.descriptor[5:4];
            2'd1:    page_ap = req.data.descriptor[7:6];
            2'd2:    page_ap = req.data.descriptor[9:8];
            default: page_ap = req.data.descriptor[11:10];
        endcase
    end

    always_comb
    begin
        walk_next   = walk_reg;
        vaddr_next  = vaddr_reg;
        kind_next   = kind_reg;
        priv_next   = priv_reg;
        domain_next = domain_reg;
        rsp_next    = '0;
        rsp_next.out_kind = OUT_DONE;

        if (req.data.func == FUNC_REQUEST)
        begin
            vaddr_next  = req.data.virt_addr;
            kind_next   = req.data.access_kind;
            priv_next   = req.data.supervisor;
            domain_next = 4'd0;
            if (!mmu_enable_reg)
            begin
                walk_next        = WALK_IDLE;
                rsp_next.address = req.data.virt_addr;
            end
            else
            begin
                walk_next         = WALK_L1;
                rsp_next.out_kind = OUT_DESC_READ;
                rsp_next.address  = table_base_reg
                                    + {18'd0, req.data.virt_addr[31:20], 2'b00};
            end
        end
        else
        begin
            case (walk_reg)
                WALK_L1:
                begin
                    domain_next = desc_domain;
                    walk_next   = WALK_IDLE;
                    case (desc_type)
                        DESC_FAULT:
                            rsp_next = make_fault(vaddr_reg, kind_reg,
                                                  FS_SECTION_XLATE, desc_domain);
                        DESC_COARSE:
                        begin
                            walk_next         = WALK_L2;
                            rsp_next.out_kind = OUT_DESC_READ;
                            rsp_next.address  = {req.data.descriptor[31:10], 10'd0}
                                                + {22'd0, vaddr_reg[19:12], 2'b00};
                        end
                        DESC_SECTION:
                        begin
                            if (!ap_allows(kind_reg, priv_reg, req.data.descriptor[11:10]))
                                rsp_next = make_fault(vaddr_reg, kind_reg,
                                                      FS_SECTION_PERM, desc_domain);
                            else
                                rsp_next.address = {req.data.descriptor[31:20],
                                                    vaddr_reg[19:0]};
                        end
                        default:
                            rsp_next.outcome = OUTCOME_UNSUPPORTED;
                    endcase
                end
                WALK_L2:
                begin
                    walk_next = WALK_IDLE;
                    if (desc_type == DESC_FAULT)
                        rsp_next = make_fault(vaddr_reg, kind_reg,
                                              FS_PAGE_XLATE, domain_reg);
                    else if (desc_type == DESC_SMALL)
                    begin
                        if (!ap_allows(kind_reg, priv_reg, page_ap))
                            rsp_next = make_fault(vaddr_reg, kind_reg,
                                                  FS_PAGE_PERM, domain_reg);
                        else
                            rsp_next.address = {req.data.descriptor[31:12],
                                                vaddr_reg[11:0]};
                    end
                    else
                        rsp_next.outcome = OUTCOME_UNSUPPORTED;
                end
                default:
                begin
                    walk_next        = WALK_IDLE;
                    rsp_next.outcome = OUTCOME_STRAY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= WALK_IDLE;
            mmu_enable_reg <= 1'b0;
            table_base_reg <= '0;
            vaddr_reg      <= '0;
            kind_reg       <= '0;
            priv_reg       <= 1'b0;
            domain_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == REG_MMU_ENABLE)
                    mmu_enable_reg <= pwdata[0];
                else
                    table_base_reg <= pwdata;
            end
            if (accept)
            begin
                walk_reg      <= walk_next;
                vaddr_reg     <= vaddr_next;
                kind_reg      <= kind_next;
                priv_reg      <= priv_next;
                domain_reg    <= domain_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    a_desc_read_walking: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.out_kind == OUT_DESC_READ) |-> (walk_reg != WALK_IDLE))
        else $error("descriptor read shown while walk is idle");

    a_fault_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.outcome == OUTCOME_FAULT) |->
            ((rsp_reg.fault_status == FS_SECTION_XLATE)
             || (rsp_reg.fault_status == FS_PAGE_XLATE)
             || (rsp_reg.fault_status == FS_SECTION_PERM)
             || (rsp_reg.fault_status == FS_PAGE_PERM)) && (walk_reg == WALK_IDLE))
        else $error("fault with bad status or walk left open");

    a_no_fault_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.outcome != OUTCOME_FAULT) |->
            (rsp_reg.fsr_value == 12'd0) && (rsp_reg.fault_status == 4'd0)
            && (rsp_reg.fsr_is_data == 1'b0))
        else $error("fault fields set without a fault");

    a_stray_reply: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.data.func == FUNC_REPLY) && (walk_reg == WALK_IDLE) |=>
            rsp_valid_reg && (rsp_reg.outcome == OUTCOME_STRAY))
        else $error("reply while idle not flagged");
`endif

endmodule
